@@ rtl/core/joystick_to_valve_drive_assert.svh @@
// assertion macros shared by the joystick to valve drive rtl
// no dependencies; the checks compile away when SYNTHESIS is defined
`ifndef JOYSTICK_TO_VALVE_DRIVE_ASSERT_SVH
`define JOYSTICK_TO_VALVE_DRIVE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define JTV_ASSERT_COMB(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define JTV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JTV_ASSERT_COMB(label, clk, rst, ante, cons, msg)
`define JTV_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/jtv_pkg.sv @@
// types and constants for the joystick to valve drive
// no dependencies
package jtv_pkg;

  localparam int CHANNELS    = 20;
  localparam int CH_W        = 5;
  localparam int DUTY_W      = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 7;

  localparam logic [7:0]        JOY_CENTRE = 8'd127;
  localparam logic [DUTY_W-1:0] FULL_DUTY  = 7'd100;

  // (d * 100) / 127 == (d * PCT_PER_127) >> 20 for d <= 128
  localparam logic [19:0] PCT_PER_127 = 20'd825700;
  localparam int          PCT_SHIFT   = 20;
  // x / 100 == (x * DIV100_MUL) >> 19 for x <= 16383
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE       = 4'd0,
    REG_RAMP_STEP      = 4'd1,
    REG_INVALID_LIMIT  = 4'd2,
    REG_ARM_DUTY_MIN   = 4'd3,
    REG_ARM_DUTY_MAX   = 4'd4,
    REG_OUTRIG_DUTY_MIN = 4'd5,
    REG_OUTRIG_DUTY_MAX = 4'd6,
    REG_CURVE_ENABLE   = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] deadzone;
    logic [6:0] ramp_step;
    logic [2:0] invalid_limit;
    logic [6:0] arm_duty_min;
    logic [6:0] arm_duty_max;
    logic [6:0] outrigger_duty_min;
    logic [6:0] outrigger_duty_max;
    logic       curve_enable;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_UPPER,
    OP_LOWER,
    OP_HOLD,
    OP_STOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] left_x;
    logic [7:0] left_y;
    logic [7:0] right_x;
    logic [7:0] right_y;
    logic       reverse;
    logic       starter;
  } frame_cmd_t;

endpackage

@@ rtl/core/jtv_if.sv @@
// handshake channels of the joystick to valve drive: frame in, duty out, config write
// depends on jtv_pkg
interface jtv_frame_if;
  import jtv_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] left_x;
  logic [7:0] left_y;
  logic [7:0] right_x;
  logic [7:0] right_y;
  logic       mode_bit_a;
  logic       mode_bit_b;
  logic       reverse_button;
  logic       starter_button;
  modport source (output valid, left_x, left_y, right_x, right_y, mode_bit_a,
                  mode_bit_b, reverse_button, starter_button, input ready);
  modport sink (input valid, left_x, left_y, right_x, right_y, mode_bit_a,
                mode_bit_b, reverse_button, starter_button, output ready);
endinterface

interface jtv_duty_if;
  import jtv_pkg::*;
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel_index;
  logic [DUTY_W-1:0] duty_percent;
  logic              starter_on;
  logic              stopped;
  logic              last_channel;
  modport source (output valid, channel_index, duty_percent, starter_on, stopped,
                  last_channel, input ready);
  modport sink (input valid, channel_index, duty_percent, starter_on, stopped,
                last_channel, output ready);
endinterface

interface jtv_cfg_if;
  import jtv_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/jtv_front.sv @@
// frame front end: accepts frames, decodes the mode, runs the invalid mode filter
// depends on jtv_pkg, jtv_if and the assertion header
`include "joystick_to_valve_drive_assert.svh"

module jtv_front (
  input  logic                clk,
  input  logic                rst,
  input  jtv_pkg::cfg_t       cfg,
  jtv_frame_if.sink           frame,
  input  logic                q_full,
  output logic                q_push,
  output jtv_pkg::frame_cmd_t q_cmd
);
  import jtv_pkg::*;

  localparam logic [1:0] SEL_ARM   = 2'b00;
  localparam logic [1:0] SEL_TRACK = 2'b01;

  logic [2:0] invalid_count;
  logic [2:0] invalid_count_next;
  logic [2:0] count_step;
  logic [1:0] mode;
  logic       accept;
  op_t        op;

  assign mode   = {frame.mode_bit_a, frame.mode_bit_b};
  assign frame.ready = !q_full && !rst;
  assign accept = frame.valid && frame.ready;

  // saturating count toward the limit
  assign count_step = (invalid_count < cfg.invalid_limit) ? invalid_count + 3'd1
                                                          : invalid_count;

  always_comb begin
    unique case (mode)
      SEL_ARM: begin
        op = OP_UPPER;
        invalid_count_next = '0;
      end
      SEL_TRACK: begin
        op = OP_LOWER;
        invalid_count_next = '0;
      end
      default: begin
        op = (count_step >= cfg.invalid_limit) ? OP_STOP : OP_HOLD;
        invalid_count_next = count_step;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      invalid_count <= '0;
    end else if (accept) begin
      invalid_count <= invalid_count_next;
    end
  end

  assign q_push        = accept;
  assign q_cmd.op      = op;
  assign q_cmd.left_x  = frame.left_x;
  assign q_cmd.left_y  = frame.left_y;
  assign q_cmd.right_x = frame.right_x;
  assign q_cmd.right_y = frame.right_y;
  assign q_cmd.reverse = frame.reverse_button;
  assign q_cmd.starter = frame.starter_button;

  `JTV_ASSERT_NEXT(a_valid_mode_clears, clk, rst, accept && (mode == SEL_ARM || mode == SEL_TRACK), invalid_count == 3'd0, "valid mode did not clear the invalid count")
  `JTV_ASSERT_NEXT(a_invalid_steps, clk, rst, accept && mode != SEL_ARM && mode != SEL_TRACK && invalid_count < cfg.invalid_limit, invalid_count == $past(invalid_count) + 3'd1, "invalid frame did not step the count")
  `JTV_ASSERT_NEXT(a_stop_at_limit, clk, rst, accept && op == OP_STOP, invalid_count >= $past(cfg.invalid_limit), "stop issued below the limit")

endmodule

@@ rtl/core/jtv_queue.sv @@
// short frame queue between the front end and the channel pipeline
// depends on jtv_pkg and the assertion header
`include "joystick_to_valve_drive_assert.svh"

module jtv_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  jtv_pkg::frame_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output jtv_pkg::frame_cmd_t head_cmd
);
  import jtv_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  frame_cmd_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `JTV_ASSERT_COMB(a_count_bound, clk, rst, 1'b1, count <= CNT_FULL, "queue count past depth")
  `JTV_ASSERT_NEXT(a_push_grows, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1, "push did not grow the queue")
  `JTV_ASSERT_NEXT(a_pop_shrinks, clk, rst, do_pop && !do_push, count == $past(count) - 1'b1, "pop did not shrink the queue")

endmodule

@@ rtl/core/jtv_back.sv @@
// channel pipeline: walks the 20 channels of a frame, maps, curves, scales and
// slew limits each one and holds the per-channel levels; depends on jtv_pkg, jtv_if
`include "joystick_to_valve_drive_assert.svh"

module jtv_back (
  input  logic                clk,
  input  logic                rst,
  input  jtv_pkg::cfg_t       cfg,
  input  logic                head_valid,
  input  jtv_pkg::frame_cmd_t head_cmd,
  output logic                pop,
  jtv_duty_if.source          duty
);
  import jtv_pkg::*;

  localparam int NSTG = 6;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  localparam logic [CH_W-1:0] CH_BRAKE     = 5'd0;
  localparam logic [CH_W-1:0] CH_PARALLEL  = 5'd1;
  localparam logic [CH_W-1:0] CH_CYL2_OUT  = 5'd2;
  localparam logic [CH_W-1:0] CH_CYL2_IN   = 5'd3;
  localparam logic [CH_W-1:0] CH_CYL3_OUT  = 5'd4;
  localparam logic [CH_W-1:0] CH_CYL3_IN   = 5'd5;
  localparam logic [CH_W-1:0] CH_CYL4_OUT  = 5'd6;
  localparam logic [CH_W-1:0] CH_CYL4_IN   = 5'd7;
  localparam logic [CH_W-1:0] CH_SLEW_CW   = 5'd10;
  localparam logic [CH_W-1:0] CH_SLEW_CCW  = 5'd11;
  localparam logic [CH_W-1:0] CH_LOUT_UP   = 5'd12;
  localparam logic [CH_W-1:0] CH_LOUT_DOWN = 5'd13;
  localparam logic [CH_W-1:0] CH_ROUT_UP   = 5'd14;
  localparam logic [CH_W-1:0] CH_ROUT_DOWN = 5'd15;
  localparam logic [CH_W-1:0] CH_RTRK_FWD  = 5'd16;
  localparam logic [CH_W-1:0] CH_RTRK_BACK = 5'd17;
  localparam logic [CH_W-1:0] CH_LTRK_FWD  = 5'd18;
  localparam logic [CH_W-1:0] CH_LTRK_BACK = 5'd19;

  typedef enum logic [1:0] {ACT_HOLD, ACT_ZERO, ACT_FULL, ACT_MAP} act_t;
  typedef enum logic [1:0] {AX_LX, AX_LY, AX_RX, AX_RY} axis_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    act_t            act;
    logic            stop;
    logic            starter;
  } tag_t;

  logic [DUTY_W-1:0] drive_level [CHANNELS];
  logic [DUTY_W-1:0] ramp_memory [CHANNELS];

  logic            en;
  logic            out_valid;
  logic [CH_W-1:0] k;
  logic [NSTG:1]   v;
  tag_t            tag [1:NSTG];

  // issue stage
  act_t       act_sel;
  act_t       act0;
  axis_t      ax0;
  logic       low0;
  logic [7:0] v0;
  logic [7:0] d0;
  logic [7:0] band_lo;
  logic [8:0] band_hi;

  // pipeline data
  logic [7:0]        d1;
  logic [27:0]       lin_prod;
  logic [7:0]        lin_pct;
  logic [DUTY_W-1:0] p2;
  logic [13:0]       x3;
  logic              curve3;
  logic [26:0]       curve_prod;
  logic [DUTY_W-1:0] p4;
  logic              outrig4;
  logic [DUTY_W-1:0] lo_sel;
  logic [DUTY_W-1:0] hi_sel;
  logic [DUTY_W-1:0] span;
  logic [13:0]       sc5;
  logic [DUTY_W-1:0] lo5;
  logic              nz5;
  logic [26:0]       scale_prod;
  logic [7:0]        scale_sum;
  logic [DUTY_W-1:0] tgt6;

  // ramp stage
  logic [7:0]        prev8;
  logic [7:0]        tgt8;
  logic [7:0]        step8;
  logic [7:0]        q8;
  logic [DUTY_W-1:0] q;
  logic [DUTY_W-1:0] level;

  assign en         = !out_valid || duty.ready;
  assign pop        = en && head_valid && (k == CH_LAST);
  assign duty.valid = out_valid;

  // which role each channel plays in this frame
  always_comb begin
    act_sel = ACT_HOLD;
    ax0     = AX_LX;
    low0    = 1'b0;
    unique case (head_cmd.op)
      OP_STOP: act_sel = ACT_ZERO;
      OP_HOLD: act_sel = ACT_HOLD;
      OP_UPPER: begin
        case (k) inside
          CH_BRAKE:    act_sel = ACT_FULL;
          CH_PARALLEL: act_sel = head_cmd.reverse ? ACT_FULL : ACT_ZERO;
          CH_CYL2_OUT: begin act_sel = ACT_MAP; ax0 = AX_RY; low0 = !head_cmd.reverse; end
          CH_CYL2_IN:  begin act_sel = ACT_MAP; ax0 = AX_RY; low0 = head_cmd.reverse; end
          CH_CYL3_OUT: begin act_sel = ACT_MAP; ax0 = AX_LY; low0 = 1'b0; end
          CH_CYL3_IN:  begin act_sel = ACT_MAP; ax0 = AX_LY; low0 = 1'b1; end
          CH_CYL4_OUT: begin act_sel = ACT_MAP; ax0 = AX_RX; low0 = 1'b1; end
          CH_CYL4_IN:  begin act_sel = ACT_MAP; ax0 = AX_RX; low0 = 1'b0; end
          CH_SLEW_CW:  begin act_sel = ACT_MAP; ax0 = AX_LX; low0 = 1'b0; end
          CH_SLEW_CCW: begin act_sel = ACT_MAP; ax0 = AX_LX; low0 = 1'b1; end
          [CH_LOUT_UP:CH_LTRK_BACK]: act_sel = ACT_ZERO;
          default:     act_sel = ACT_HOLD;
        endcase
      end
      OP_LOWER: begin
        case (k) inside
          [CH_BRAKE:CH_CYL3_IN]:   act_sel = ACT_ZERO;
          CH_SLEW_CW, CH_SLEW_CCW: act_sel = ACT_ZERO;
          CH_LOUT_UP:   begin act_sel = ACT_MAP; ax0 = AX_LX; low0 = 1'b0; end
          CH_LOUT_DOWN: begin act_sel = ACT_MAP; ax0 = AX_LX; low0 = 1'b1; end
          CH_ROUT_UP:   begin act_sel = ACT_MAP; ax0 = AX_RX; low0 = 1'b1; end
          CH_ROUT_DOWN: begin act_sel = ACT_MAP; ax0 = AX_RX; low0 = 1'b0; end
          CH_RTRK_FWD:  begin act_sel = ACT_MAP; ax0 = AX_RY; low0 = 1'b0; end
          CH_RTRK_BACK: begin act_sel = ACT_MAP; ax0 = AX_RY; low0 = 1'b1; end
          CH_LTRK_FWD:  begin act_sel = ACT_MAP; ax0 = AX_LY; low0 = 1'b0; end
          CH_LTRK_BACK: begin act_sel = ACT_MAP; ax0 = AX_LY; low0 = 1'b1; end
          default:      act_sel = ACT_HOLD;
        endcase
      end
      default: act_sel = ACT_HOLD;
    endcase
  end

  // deadzone test; a mapped channel not past its own edge of the band is an explicit zero
  always_comb begin
    case (ax0)
      AX_LX:   v0 = head_cmd.left_x;
      AX_LY:   v0 = head_cmd.left_y;
      AX_RX:   v0 = head_cmd.right_x;
      default: v0 = head_cmd.right_y;
    endcase
    band_lo = JOY_CENTRE - {1'b0, cfg.deadzone};
    band_hi = {1'b0, JOY_CENTRE} + {2'b00, cfg.deadzone};
    act0    = act_sel;
    d0      = '0;
    if (act_sel == ACT_MAP) begin
      if (low0) begin
        if (v0 < band_lo) d0 = JOY_CENTRE - v0;
        else act0 = ACT_ZERO;
      end else begin
        if ({1'b0, v0} > band_hi) d0 = v0 - JOY_CENTRE;
        else act0 = ACT_ZERO;
      end
    end
  end

  // stage 2: axis offset to percent
  assign lin_prod = 28'(d1) * 28'(PCT_PER_127);
  assign lin_pct  = lin_prod[PCT_SHIFT +: 8];

  // stage 4: square over 100
  assign curve_prod = 27'(x3) * 27'(DIV100_MUL);

  // stage 5: group bounds
  assign outrig4 = (tag[4].ch >= CH_LOUT_UP) && (tag[4].ch <= CH_ROUT_DOWN);
  assign lo_sel  = outrig4 ? cfg.outrigger_duty_min : cfg.arm_duty_min;
  assign hi_sel  = outrig4 ? cfg.outrigger_duty_max : cfg.arm_duty_max;
  assign span    = (hi_sel >= lo_sel) ? hi_sel - lo_sel : '0;

  // stage 6: min + p*span/100
  assign scale_prod = 27'(sc5) * 27'(DIV100_MUL);
  assign scale_sum  = {1'b0, lo5} + {1'b0, scale_prod[DIV100_SHIFT +: DUTY_W]};

  // ramp against this channel's memory
  always_comb begin
    prev8 = {1'b0, ramp_memory[tag[NSTG].ch]};
    tgt8  = {1'b0, tgt6};
    step8 = {1'b0, cfg.ramp_step};
    if (tgt8 > prev8 && (tgt8 - prev8) > step8) q8 = prev8 + step8;
    else if (prev8 > tgt8 && (prev8 - tgt8) > step8) q8 = prev8 - step8;
    else q8 = tgt8;
    q = (q8 > {1'b0, FULL_DUTY}) ? FULL_DUTY : q8[DUTY_W-1:0];
    case (tag[NSTG].act)
      ACT_MAP:  level = q;
      ACT_ZERO: level = '0;
      ACT_FULL: level = FULL_DUTY;
      default:  level = drive_level[tag[NSTG].ch];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
      k         <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        drive_level[i] <= '0;
        ramp_memory[i] <= '0;
      end
    end else if (en) begin
      v         <= {v[NSTG-1:1], head_valid};
      out_valid <= v[NSTG];
      if (head_valid) begin
        k <= (k == CH_LAST) ? '0 : k + 1'b1;
      end
      if (v[NSTG]) begin
        drive_level[tag[NSTG].ch] <= level;
        if (tag[NSTG].act == ACT_MAP) begin
          ramp_memory[tag[NSTG].ch] <= q;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      tag[1] <= '{ch: k, act: act0, stop: (head_cmd.op == OP_STOP),
                  starter: head_cmd.starter};
      for (int i = 2; i <= NSTG; i++) begin
        tag[i] <= tag[i-1];
      end
      d1     <= d0;
      p2     <= (lin_pct > {1'b0, FULL_DUTY}) ? FULL_DUTY : lin_pct[DUTY_W-1:0];
      x3     <= cfg.curve_enable ? 14'(p2) * 14'(p2) : 14'(p2);
      curve3 <= cfg.curve_enable;
      p4     <= curve3 ? curve_prod[DIV100_SHIFT +: DUTY_W] : x3[DUTY_W-1:0];
      sc5    <= 14'(p4) * 14'(span);
      lo5    <= lo_sel;
      nz5    <= (p4 != '0);
      tgt6   <= !nz5 ? '0
              : (scale_sum > {1'b0, FULL_DUTY}) ? FULL_DUTY : scale_sum[DUTY_W-1:0];
      if (v[NSTG]) begin
        duty.channel_index <= tag[NSTG].ch;
        duty.duty_percent  <= level;
        duty.starter_on    <= tag[NSTG].starter;
        duty.stopped       <= tag[NSTG].stop;
        duty.last_channel  <= (tag[NSTG].ch == CH_LAST);
      end
    end
  end

  `JTV_ASSERT_COMB(a_duty_range, clk, rst, out_valid, duty.duty_percent <= FULL_DUTY, "duty above full scale")
  `JTV_ASSERT_COMB(a_last_is_19, clk, rst, out_valid && duty.last_channel, duty.channel_index == CH_LAST, "last flag on a wrong channel")
  `JTV_ASSERT_NEXT(a_walk_wraps, clk, rst, en && head_valid && k == CH_LAST, k == '0 && v[1], "channel walk did not wrap after the last channel")

endmodule

@@ rtl/core/joystick_to_valve_drive.sv @@
// top level of the joystick to valve drive: config registers, front end,
// frame queue and channel pipeline; depends on jtv_pkg, jtv_if and the submodules
//
//  channel | dir | one request carries
//  --------+-----+---------------------------------------------------------
//  frame   | in  | four stick axes, two mode bits, reverse and starter
//  duty    | out | channel_index, duty_percent, starter_on, stopped, last_channel
//  cfg     | in  | register index and write data
//
// each frame yields 20 duty requests, one per cycle from the channel pipeline
// when the duty side keeps up. a duty stall freezes the whole pipeline; the
// two-entry queue keeps taking frames until it is full.
// rst is synchronous and clears the control state, channel levels and config
// registers, but not the queue entries or the pipeline payload registers; frame
// and config are not ready while rst is high, config is ready at all other times.

module joystick_to_valve_drive (
  input  logic       clk,
  input  logic       rst,
  jtv_frame_if.sink  frame,
  jtv_duty_if.source duty,
  jtv_cfg_if.sink    cfg
);
  import jtv_pkg::*;

  cfg_t       cfg_regs;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       head_valid;
  frame_cmd_t push_cmd;
  frame_cmd_t head_cmd;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.deadzone           <= 7'd5;
      cfg_regs.ramp_step          <= 7'd10;
      cfg_regs.invalid_limit      <= 3'd5;
      cfg_regs.arm_duty_min       <= 7'd0;
      cfg_regs.arm_duty_max       <= 7'd70;
      cfg_regs.outrigger_duty_min <= 7'd0;
      cfg_regs.outrigger_duty_max <= 7'd100;
      cfg_regs.curve_enable       <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DEADZONE:        cfg_regs.deadzone           <= cfg.data;
        REG_RAMP_STEP:       cfg_regs.ramp_step          <= cfg.data;
        REG_INVALID_LIMIT:   cfg_regs.invalid_limit      <= cfg.data[2:0];
        REG_ARM_DUTY_MIN:    cfg_regs.arm_duty_min       <= cfg.data;
        REG_ARM_DUTY_MAX:    cfg_regs.arm_duty_max       <= cfg.data;
        REG_OUTRIG_DUTY_MIN: cfg_regs.outrigger_duty_min <= cfg.data;
        REG_OUTRIG_DUTY_MAX: cfg_regs.outrigger_duty_max <= cfg.data;
        REG_CURVE_ENABLE:    cfg_regs.curve_enable       <= cfg.data[0];
        default: ;
      endcase
    end
  end

  jtv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_regs),
    .frame  (frame),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  jtv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  jtv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .duty       (duty)
  );

endmodule
